[hdl/zpm_pkg.sv]
// ----------------------------------------------------------------------------
// Zoom magnification package
// Types, breakpoint tables and reciprocal constants shared by the zoom
// position to magnification converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zpm_pkg;

    localparam int POS_W   = 16;
    localparam int SEG_W   = 4;
    localparam int NUM_PTS = 12;
    localparam int OFF_W   = 13;   // widest segment span is 0x2000
    localparam int NUM_W   = 17;   // 12 times the offset
    localparam int MAG_W16 = 16;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [SEG_W-1:0]   seg_t;
    typedef logic [MAG_W16-1:0] mag_t;

    localparam pos_t DIGITAL_START = 16'h4000;
    localparam pos_t DIGITAL_END   = 16'h7AC0;
    localparam logic [7:0] MAG_FULL    = 8'd144;
    localparam logic [7:0] OPTICAL_MAX = 8'd12;
    localparam mag_t FIELD_MAX = 16'hFFFF;

    // Span division: q = (num * ceil(2^42 / span)) >> (42 - frac bits).
    // Exact because num * 2^frac * span stays below 2^42.
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_W     = 36;
    typedef logic [RECIP_W-1:0] recip_t;
    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

    // Divide by five for the smoothing: (x * ceil(2^22 / 5)) >> 22, x < 2^19.
    localparam int SM_SHIFT = 22;
    localparam int SM_ACC_W = 19;
    localparam int DIV5_W   = 20;
    localparam logic [DIV5_W-1:0] DIV5_RECIP = 20'd838861;

    typedef struct packed {
        logic full;      // at or past the end of the digital table
        logic digital;   // digital table in use
        seg_t seg;       // index of the first point above the position, 1..11
    } zpm_seg_t;

    localparam pos_t OPT_PTS [NUM_PTS] = '{
        16'h0000, 16'h1970, 16'h249C, 16'h2B5F, 16'h3020, 16'h33C4,
        16'h36B7, 16'h392F, 16'h3B4D, 16'h3D1E, 16'h3EAD, 16'h4000
    };

    localparam pos_t DIG_PTS [NUM_PTS] = '{
        16'h4000, 16'h6000, 16'h6A80, 16'h7000, 16'h7300, 16'h7540,
        16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00, 16'h7AC0
    };

    // Entry i belongs to the segment that ends at point i; entry 0 is unused.
    localparam recip_t OPT_RECIP [NUM_PTS] = '{
        36'd0,
        recip_t'((RECIP_ONE + 64'd6511) / 64'd6512),
        recip_t'((RECIP_ONE + 64'd2859) / 64'd2860),
        recip_t'((RECIP_ONE + 64'd1730) / 64'd1731),
        recip_t'((RECIP_ONE + 64'd1216) / 64'd1217),
        recip_t'((RECIP_ONE + 64'd931) / 64'd932),
        recip_t'((RECIP_ONE + 64'd754) / 64'd755),
        recip_t'((RECIP_ONE + 64'd631) / 64'd632),
        recip_t'((RECIP_ONE + 64'd541) / 64'd542),
        recip_t'((RECIP_ONE + 64'd464) / 64'd465),
        recip_t'((RECIP_ONE + 64'd398) / 64'd399),
        recip_t'((RECIP_ONE + 64'd338) / 64'd339)
    };

    localparam recip_t DIG_RECIP [NUM_PTS] = '{
        36'd0,
        recip_t'((RECIP_ONE + 64'd8191) / 64'd8192),
        recip_t'((RECIP_ONE + 64'd2687) / 64'd2688),
        recip_t'((RECIP_ONE + 64'd1407) / 64'd1408),
        recip_t'((RECIP_ONE + 64'd767) / 64'd768),
        recip_t'((RECIP_ONE + 64'd575) / 64'd576),
        recip_t'((RECIP_ONE + 64'd383) / 64'd384),
        recip_t'((RECIP_ONE + 64'd319) / 64'd320),
        recip_t'((RECIP_ONE + 64'd191) / 64'd192),
        recip_t'((RECIP_ONE + 64'd191) / 64'd192),
        recip_t'((RECIP_ONE + 64'd127) / 64'd128),
        recip_t'((RECIP_ONE + 64'd191) / 64'd192)
    };

endpackage

[hdl/zpm_interp.sv]
// ----------------------------------------------------------------------------
// Zoom segment search and interpolation
// Finds the table segment of a zoom position and computes the fractional
// part of the magnification with one reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zpm_interp #(
    parameter int FRAC_BITS = 8
) (
    input  zpm_pkg::pos_t       pos,
    output zpm_pkg::zpm_seg_t   seg_info,
    output logic [FRAC_BITS+3:0] frac
);
    import zpm_pkg::*;

    localparam int FRAC_W = FRAC_BITS + 4;
    localparam int PROD_W = NUM_W + RECIP_W;
    localparam int Q_LSB  = RECIP_SHIFT - FRAC_BITS;

    logic               full;
    logic               digital;
    seg_t               cnt;
    seg_t               seg;
    pos_t               lo_pt;
    logic [OFF_W-1:0]   off;
    logic [NUM_W-1:0]   num;
    recip_t             recip;
    logic [PROD_W-1:0]  prod;

    always_comb begin
        full    = (pos >= DIGITAL_END);
        digital = (pos >= DIGITAL_START);

        // count the inner points at or below the position
        cnt = '0;
        for (int k = 1; k < NUM_PTS - 1; k++) begin
            if (digital ? (pos >= DIG_PTS[k]) : (pos >= OPT_PTS[k])) begin
                cnt = cnt + SEG_W'(1);
            end
        end
        seg = cnt + SEG_W'(1);

        lo_pt = digital ? DIG_PTS[cnt] : OPT_PTS[cnt];
        off   = OFF_W'(pos - lo_pt);
        num   = digital ? ((NUM_W'(off) << 3) + (NUM_W'(off) << 2)) : NUM_W'(off);
        recip = digital ? DIG_RECIP[seg] : OPT_RECIP[seg];
        prod  = PROD_W'(num) * PROD_W'(recip);
    end

    assign frac     = prod[Q_LSB +: FRAC_W];
    assign seg_info = '{full: full, digital: digital, seg: seg};

endmodule

[hdl/zpm_smooth.sv]
// ----------------------------------------------------------------------------
// Magnification smoother
// Holds the smoothed magnification and forms floor((4 * old + new) / 5).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zpm_smooth (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  zpm_pkg::mag_t mag,
    output zpm_pkg::mag_t sm_next
);
    import zpm_pkg::*;

    localparam int PROD_W = SM_ACC_W + DIV5_W;

    mag_t                smooth_reg;
    logic [SM_ACC_W-1:0] acc;
    logic [PROD_W-1:0]   prod;

    always_comb begin
        acc     = (SM_ACC_W'(smooth_reg) << 2) + SM_ACC_W'(mag);
        prod    = PROD_W'(acc) * PROD_W'(DIV5_RECIP);
        sm_next = prod[SM_SHIFT +: MAG_W16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
        end else if (load) begin
            smooth_reg <= sm_next;
        end
    end

    // the new value lies between the old one and the new sample
    a_rise_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (mag >= smooth_reg) |-> (sm_next >= smooth_reg) && (sm_next <= mag))
        else $error("smoothed value left [old, new] on a rising sample");

    a_fall_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        load && (mag < smooth_reg) |-> (sm_next <= smooth_reg) && (sm_next >= mag))
        else $error("smoothed value left [new, old] on a falling sample");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> smooth_reg == $past(smooth_reg))
        else $error("smoothed state changed without a word");

endmodule

[hdl/zoom_position_to_magnification.sv]
// ----------------------------------------------------------------------------
// Zoom position to magnification
// Each zoom position word is converted to a magnification by linear
// interpolation over a 12-point optical table below 0x4000 and a 12-point
// digital table (times 12) above it; positions at or past 0x7AC0 give 144.
// The result and a smoothed copy (0.8 old + 0.2 new, truncated) leave as
// unsigned fixed point with FRAC_BITS fraction bits. One word is taken every
// cycle unless output backpressure holds the input. The result word passes
// through the stage register and then the output register. The segment compare
// bank and the reciprocal multiply for the span sit ahead of the stage register.
// The stage after it adds the segment base, saturates, and updates the
// smoother, whose state feeds back within that stage. Output backpressure
// holds the stage and then the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zoom_position_to_magnification #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] zoom_position
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [15:0] magnification_now,
                                            // [31:16] magnification_smoothed
);
    import zpm_pkg::*;

    localparam int FRAC_W = FRAC_BITS + 4;
    localparam int MAG_W  = FRAC_BITS + 8;
    localparam int EXT_W  = (MAG_W > MAG_W16) ? MAG_W : MAG_W16;
    localparam logic [EXT_W-1:0] MAG_CAP_W = EXT_W'(MAG_FULL) << FRAC_BITS;
    localparam logic [EXT_W-1:0] DIG_MIN_W = EXT_W'(OPTICAL_MAX) << FRAC_BITS;

    zpm_seg_t              seg_c;
    logic [FRAC_W-1:0]     frac_c;

    logic                  s1_valid_reg, s1_valid_next;
    zpm_seg_t              s1_seg_reg;
    logic [FRAC_W-1:0]     s1_frac_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    mag_t                  m_mag_reg;
    mag_t                  m_sm_reg;

    logic                  s_accept;
    logic                  out_load;
    logic [7:0]            seg_mag;
    logic [EXT_W-1:0]      mag_wide;
    mag_t                  mag_now;
    mag_t                  sm_next;

    zpm_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .pos      (s_tdata),
        .seg_info (seg_c),
        .frac     (frac_c)
    );

    // handshake: stage 1 advances whenever the output register is free
    always_comb begin
        out_load      = s1_valid_reg && (!m_tvalid_reg || m_tready);
        s_tready      = !s1_valid_reg || out_load;
        s_accept      = s_tvalid && s_tready;
        s1_valid_next = s_accept || (s1_valid_reg && !out_load);
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_seg_reg  <= seg_c;
            s1_frac_reg <= frac_c;
        end
    end

    // add the segment base (or take full scale at the table end), then clamp to the 16-bit field
    always_comb begin
        seg_mag = s1_seg_reg.digital ? (8'(s1_seg_reg.seg) * OPTICAL_MAX)
                                     : 8'(s1_seg_reg.seg);
        if (s1_seg_reg.full) begin
            mag_wide = MAG_CAP_W;
        end else begin
            mag_wide = (EXT_W'(seg_mag) << FRAC_BITS) + EXT_W'(s1_frac_reg);
        end
        mag_now = (mag_wide > EXT_W'(FIELD_MAX)) ? FIELD_MAX : mag_wide[MAG_W16-1:0];
    end

    zpm_smooth u_smooth (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .mag     (mag_now),
        .sm_next (sm_next)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mag_reg <= mag_now;
            m_sm_reg  <= sm_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_sm_reg, m_mag_reg};

    a_mag_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> EXT_W'(m_mag_reg) <= MAG_CAP_W)
        else $error("magnification above full scale");

    a_full_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_seg_reg.full |-> mag_wide == MAG_CAP_W)
        else $error("end-of-table position did not give full scale");

    a_digital_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_seg_reg.digital |-> mag_wide >= DIG_MIN_W)
        else $error("digital range below optical full scale");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_frac_reg)
            && $stable(s1_seg_reg))
        else $error("stalled stage 1 word changed");

endmodule
